@@ hw/rtl/ismn_pkg.sv @@
// ismn_pkg: shared types, codes and small arithmetic helpers for the ISMN check verifier
// no dependencies; used by ismn_digit_step and the top level ismn_check_digit_verifier
package ismn_pkg;

    // path codes
    localparam logic [1:0] MODE_UNDECIDED = 2'd0;
    localparam logic [1:0] MODE_M10       = 2'd1;
    localparam logic [1:0] MODE_G13       = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_MATCH    = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_REJECT   = 2'd2;

    // form codes
    localparam logic FORM_G13 = 1'b0;
    localparam logic FORM_M10 = 1'b1;

    // character codes
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [6:0] EXP_ZERO  = 7'h30;
    localparam logic [6:0] EXP_X     = 7'h58;

    // length and count limits, as zero-based positions
    localparam logic [4:0] COUNT_MAX      = 5'd31;
    localparam logic [4:0] M10_POS_LAST   = 5'd12;
    localparam logic [4:0] M10_POS_MIN    = 5'd9;
    localparam logic [4:0] G13_POS_LAST   = 5'd17;
    localparam logic [4:0] G13_POS_MIN    = 5'd12;
    localparam logic [4:0] G13_PREFIX_END = 5'd3;
    localparam logic [3:0] G13_DIGITS     = 4'd12;

    typedef struct packed {
        logic [4:0] char_count;
        logic [3:0] digit_count;
        logic [3:0] res11;
        logic [3:0] res10;
        logic [1:0] mode;
        logic       reject;
    } t_state;

    typedef struct packed {
        logic [1:0] status;
        logic       form_kind;
        logic [6:0] expected_check;
    } t_result;

    // value mod 11 for values below 128: reciprocal multiply, one correction
    function automatic logic [3:0] f_mod11(input logic [6:0] value);
        logic [14:0] prod;
        logic [3:0]  quot;
        logic [6:0]  rem;
        prod = 15'(value) * 15'd186;
        quot = prod[14:11];
        rem  = value - (7'(quot) * 7'd11);
        if (rem >= 7'd11) begin
            rem = rem - 7'd11;
        end
        return rem[3:0];
    endfunction

    // value mod 10 for values below 64: reciprocal multiply, one correction
    function automatic logic [3:0] f_mod10(input logic [5:0] value);
        logic [11:0] prod;
        logic [2:0]  quot;
        logic [5:0]  rem;
        prod = 12'(value) * 12'd51;
        quot = prod[11:9];
        rem  = value - (6'(quot) * 6'd10);
        if (rem >= 6'd10) begin
            rem = rem - 6'd10;
        end
        return rem[3:0];
    endfunction

endpackage

@@ hw/rtl/ismn_if.sv @@
// ismn_in_if / ismn_out_if: valid-ready channels of the ISMN check verifier
// no dependencies
interface ismn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface ismn_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       form_kind;
    logic [6:0] expected_check;

    modport source (output valid, output status, output form_kind, output expected_check,
                    input ready);
    modport sink   (input valid, input status, input form_kind, input expected_check,
                    output ready);
endinterface

@@ hw/rtl/ismn_in_stage.sv @@
// ismn_in_stage: input register of the ISMN check verifier
// depends on ismn_if.sv
module ismn_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ismn_in_if.sink       i_in,
    input  logic          i_out_blocked,
    output logic          o_advance,
    output logic [7:0]    o_char,
    output logic          o_last
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;

    // only a last character needs room in the result register
    assign o_advance  = r_valid && !(r_last && i_out_blocked);
    assign i_in.ready = !r_valid || o_advance;
    assign o_char     = r_char;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_char <= i_in.char_in;
            r_last <= i_in.is_last;
        end
    end

endmodule

@@ hw/rtl/ismn_digit_step.sv @@
// ismn_digit_step: per-character state update and end-of-identifier result
// depends on ismn_pkg
module ismn_digit_step (
    input  ismn_pkg::t_state  i_state,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    output ismn_pkg::t_state  o_next,
    output ismn_pkg::t_result o_result
);

    logic       pos0;
    logic       is_digit;
    logic       is_hyphen;
    logic [3:0] digit_val;
    logic [7:0] want;
    logic [1:0] mode;
    logic       rej;
    logic [3:0] weight;
    logic [6:0] prod;
    logic [6:0] sum11;
    logic [5:0] sum10;
    logic [3:0] r10;
    logic [6:0] expect_m;
    logic [6:0] expect_g;

    assign pos0      = (i_state.char_count == 5'd0);
    assign is_digit  = (i_char >= ismn_pkg::CH_ZERO) && (i_char <= ismn_pkg::CH_NINE);
    assign is_hyphen = (i_char == ismn_pkg::CH_HYPHEN);
    assign digit_val = i_char[3:0];

    // weight 2,3,4.. on the M path, 1,3,1,3 on the thirteen path
    assign weight = (mode == ismn_pkg::MODE_M10) ? (i_state.digit_count + 4'd2)
                  : (i_state.digit_count[0] ? 4'd3 : 4'd1);
    assign prod   = 7'(weight) * 7'(digit_val);
    assign sum11  = 7'(i_state.res11) + prod;
    assign sum10  = 6'(i_state.res10) + prod[5:0];

    assign r10      = i_state.res10;
    assign expect_m = (i_state.res11 < 4'd10) ? (ismn_pkg::EXP_ZERO + 7'(i_state.res11))
                    : ismn_pkg::EXP_X;
    assign expect_g = (r10 == 4'd0) ? ismn_pkg::EXP_ZERO
                    : (ismn_pkg::EXP_ZERO + 7'(4'd10 - r10));

    always_comb begin
        unique case (i_state.char_count)
            5'd1:    want = ismn_pkg::CH_SEVEN;
            5'd2:    want = ismn_pkg::CH_NINE;
            default: want = ismn_pkg::CH_ZERO;
        endcase
    end

    always_comb begin
        mode = i_state.mode;
        rej  = i_state.reject;
        if (pos0) begin
            if (i_char == ismn_pkg::CH_M) begin
                mode = ismn_pkg::MODE_M10;
            end else if (i_char == ismn_pkg::CH_NINE) begin
                mode = ismn_pkg::MODE_G13;
            end else begin
                rej = 1'b1;
            end
        end else if (i_state.mode == ismn_pkg::MODE_G13
                     && i_state.char_count <= ismn_pkg::G13_PREFIX_END) begin
            if (i_char != want) begin
                rej = 1'b1;
            end
        end
    end

    always_comb begin
        o_next        = i_state;
        o_next.mode   = mode;
        o_next.reject = rej;
        if (!i_last && !rej) begin
            if (mode == ismn_pkg::MODE_M10) begin
                if (i_state.char_count >= ismn_pkg::M10_POS_LAST) begin
                    o_next.reject = 1'b1;
                end else if (!pos0) begin
                    if (!is_digit && !is_hyphen) begin
                        o_next.reject = 1'b1;
                    end else if (is_digit) begin
                        o_next.res11       = ismn_pkg::f_mod11(sum11);
                        o_next.digit_count = i_state.digit_count + 4'd1;
                    end
                end
            end else if (mode == ismn_pkg::MODE_G13) begin
                if (i_state.char_count >= ismn_pkg::G13_POS_LAST) begin
                    o_next.reject = 1'b1;
                end else if (i_state.digit_count < ismn_pkg::G13_DIGITS) begin
                    if (!is_digit && !is_hyphen) begin
                        o_next.reject = 1'b1;
                    end else if (is_digit) begin
                        o_next.res10       = ismn_pkg::f_mod10(sum10);
                        o_next.digit_count = i_state.digit_count + 4'd1;
                    end
                end
            end
        end
        if (i_state.char_count != ismn_pkg::COUNT_MAX) begin
            o_next.char_count = i_state.char_count + 5'd1;
        end
        if (i_last) begin
            o_next = '0;
        end
    end

    always_comb begin
        o_result.status         = ismn_pkg::STATUS_REJECT;
        o_result.form_kind      = ismn_pkg::FORM_G13;
        o_result.expected_check = 7'd0;
        if (!rej) begin
            if (mode == ismn_pkg::MODE_M10
                && i_state.char_count >= ismn_pkg::M10_POS_MIN
                && i_state.char_count <= ismn_pkg::M10_POS_LAST) begin
                o_result.form_kind      = ismn_pkg::FORM_M10;
                o_result.expected_check = expect_m;
                o_result.status         = (i_char == {1'b0, expect_m})
                                        ? ismn_pkg::STATUS_MATCH : ismn_pkg::STATUS_MISMATCH;
            end else if (mode == ismn_pkg::MODE_G13
                         && i_state.char_count >= ismn_pkg::G13_POS_MIN
                         && i_state.char_count <= ismn_pkg::G13_POS_LAST
                         && i_state.digit_count == ismn_pkg::G13_DIGITS) begin
                o_result.expected_check = expect_g;
                o_result.status         = (i_char == {1'b0, expect_g})
                                        ? ismn_pkg::STATUS_MATCH : ismn_pkg::STATUS_MISMATCH;
            end
        end
    end

endmodule

@@ hw/rtl/ismn_check_digit_verifier.sv @@
// ismn_check_digit_verifier: top level of the ISMN check-character verifier
// depends on ismn_pkg, ismn_if.sv, ismn_in_stage, ismn_digit_step
//
//   channel | dir | transfer                                | payload
//   i_in    | in  | one identifier character                | char_in[7:0], is_last
//   o_out   | out | one result per identifier (on is_last)  | status[1:0], form_kind,
//           |     |                                         | expected_check[6:0]
//
// one character per cycle sustained, but a last character waits for a free result register;
// the result is valid on o_out once its last character is written into the result register
// transfer: input register, then one pass through ismn_digit_step into the result register
// synchronous active-low reset clears the input valid, the running state and the result valid
// a stalled o_out only holds back a last character; other characters keep flowing
// while the result register is full and not yet taken
module ismn_check_digit_verifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ismn_in_if.sink    i_in,
    ismn_out_if.source o_out
);

    // input register stage
    logic       w_advance;
    logic [7:0] w_char;
    logic       w_last;
    logic       w_out_blocked;

    // running per-identifier state and result register
    ismn_pkg::t_state  r_state;
    ismn_pkg::t_state  n_state;
    ismn_pkg::t_result w_result;
    ismn_pkg::t_result r_result;
    logic              r_out_valid;

    // result register is busy until its transfer completes
    assign w_out_blocked = r_out_valid && !o_out.ready;

    ismn_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_out_blocked (w_out_blocked),
        .o_advance     (w_advance),
        .o_char        (w_char),
        .o_last        (w_last)
    );

    // one character step: prefix and length checks, weighted sum kept as a residue
    ismn_digit_step u_digit_step (
        .i_state  (r_state),
        .i_char   (w_char),
        .i_last   (w_last),
        .o_next   (n_state),
        .o_result (w_result)
    );

    // state advances on every character that leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result valid: set by a last character, cleared by the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_last) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_result.status;
    assign o_out.form_kind      = r_result.form_kind;
    assign o_out.expected_check = r_result.expected_check;

    // a last character only moves when the result register is free or being emptied
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_last) |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten before its transfer");

    // the running state starts clean after every identifier
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_last) |=> (r_state == '0))
        else $error("state not cleared after last character");

    // the thirteen path never takes more than twelve digits
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.digit_count <= ismn_pkg::G13_DIGITS)
        else $error("digit count out of range");

    // a rejected identifier carries no form and no check character
    a_reject_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.status == ismn_pkg::STATUS_REJECT)
        |-> (r_result.form_kind == ismn_pkg::FORM_G13 && r_result.expected_check == 7'd0))
        else $error("rejected result with nonzero fields");

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for ismn_check_digit_verifier, one character per input transfer
// depends on ismn_pkg (codes, result type) and ismn_if.sv (in/out channels)
// a built-in predictor scans the accepted characters and queues one verdict per identifier
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ismn_pkg::*;

    // arithmetic of the two forms
    localparam int unsigned M10_MODULUS = 11;
    localparam int unsigned M10_WEIGHT0 = 2;
    localparam int unsigned G13_MODULUS = 10;
    localparam int unsigned G13_BIAS    = 400;

    localparam logic [7:0] CH_UPPER_X = {1'b0, EXP_X};
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    localparam int ITEM_TARGET = 780;   // directed plus about 750 random characters
    localparam int IDLE_PCT    = 26;
    localparam int MAX_REPORTS = 10;

    // running scan of one identifier
    typedef struct packed {
        logic [4:0] n_chars;
        logic [3:0] n_digits;
        logic [9:0] wsum;
        logic [1:0] path;
        logic       bad;
    } scan_t;

    // one character waiting to be sent; hold makes the sender wait for a full drain
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       hold;
    } char_item_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ismn_in_if  in_ch ();
    ismn_out_if out_ch ();

    ismn_check_digit_verifier uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    char_item_t char_q[$];      // characters still to be sent
    t_result    verdict_q[$];   // predicted verdicts not yet seen on o_out
    logic [7:0] id_buf[$];      // identifier under construction, without its check byte
    scan_t      scan = '0;      // predictor state, follows the accepted characters
    t_result    verdict;
    t_result    want;
    logic       got;
    char_item_t cur;
    logic       in_taken = 1'b0;
    int         cyc = 0;
    int         taken_count = 0;
    int         total_items = 0;
    int         errors = 0;
    logic       calm;

    // both sides stop idling for a stretch early in the run
    assign calm = (cyc >= 300) && (cyc < 700);

    // ------------------------------------------------------------------
    // predictor: feed one character, get a verdict when it is the last one
    // ------------------------------------------------------------------
    function automatic void scan_char(ref scan_t st, input logic [7:0] ch, input logic last,
                                      output logic done, output t_result res);
        logic [4:0]  pos;
        logic        is_digit;
        logic        is_hyphen;
        int unsigned val;
        int unsigned rem;
        logic [7:0]  want_ch;
        pos       = st.n_chars;
        is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_hyphen = (ch == CH_HYPHEN);
        val       = int'(ch) - int'(CH_ZERO);
        done      = 1'b0;
        res       = '0;

        // first byte picks the form, the thirteen form then needs the rest of its prefix
        if (pos == 5'd0) begin
            if (ch == CH_M) begin
                st.path = MODE_M10;
            end else if (ch == CH_NINE) begin
                st.path = MODE_G13;
            end else begin
                st.bad = 1'b1;
            end
        end else if (st.path == MODE_G13 && pos <= G13_PREFIX_END) begin
            case (pos)
                5'd1:    want_ch = CH_SEVEN;
                5'd2:    want_ch = CH_NINE;
                default: want_ch = CH_ZERO;
            endcase
            if (ch != want_ch) begin
                st.bad = 1'b1;
            end
        end

        // body characters: digits accumulate, hyphens are skipped, anything else rejects
        if (!last && !st.bad) begin
            if (st.path == MODE_M10) begin
                if (pos >= M10_POS_LAST) begin
                    st.bad = 1'b1;
                end else if (pos >= 5'd1) begin
                    if (is_digit) begin
                        st.wsum     = 10'(st.wsum + (st.n_digits + M10_WEIGHT0) * val);
                        st.n_digits = st.n_digits + 4'd1;
                    end else if (!is_hyphen) begin
                        st.bad = 1'b1;
                    end
                end
            end else if (st.path == MODE_G13) begin
                if (pos >= G13_POS_LAST) begin
                    st.bad = 1'b1;
                end else if (st.n_digits < G13_DIGITS) begin
                    if (is_digit) begin
                        st.wsum     = 10'(st.wsum + (st.n_digits[0] ? 3 : 1) * val);
                        st.n_digits = st.n_digits + 4'd1;
                    end else if (!is_hyphen) begin
                        st.bad = 1'b1;
                    end
                end
                // past twelve digits the body is not looked at
            end
        end

        // length counter saturates
        if (st.n_chars != COUNT_MAX) begin
            st.n_chars = st.n_chars + 5'd1;
        end

        if (last) begin
            done       = 1'b1;
            res.status = STATUS_REJECT;
            res.form_kind = FORM_G13;
            res.expected_check = '0;
            if (!st.bad) begin
                if (st.path == MODE_M10 && pos >= M10_POS_MIN && pos <= M10_POS_LAST) begin
                    rem = st.wsum % M10_MODULUS;
                    res.expected_check = (rem < 10) ? 7'(EXP_ZERO + rem) : EXP_X;
                    res.form_kind = FORM_M10;
                    res.status = (ch == {1'b0, res.expected_check}) ? STATUS_MATCH
                                                                    : STATUS_MISMATCH;
                end else if (st.path == MODE_G13 && pos >= G13_POS_MIN && pos <= G13_POS_LAST
                             && st.n_digits == G13_DIGITS) begin
                    rem = (G13_BIAS - st.wsum) % G13_MODULUS;
                    res.expected_check = 7'(EXP_ZERO + rem);
                    res.form_kind = FORM_G13;
                    res.status = (ch == {1'b0, res.expected_check}) ? STATUS_MATCH
                                                                    : STATUS_MISMATCH;
                end
            end
            st = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // identifier builders
    // ------------------------------------------------------------------
    // correct check byte for a body, zero when the body is already malformed
    function automatic logic [7:0] right_check(input logic [7:0] body[$]);
        scan_t   st;
        logic    done;
        t_result res;
        st = '0;
        foreach (body[i]) begin
            scan_char(st, body[i], 1'b0, done, res);
        end
        scan_char(st, CH_ZERO, 1'b1, done, res);
        return {1'b0, res.expected_check};
    endfunction

    // mostly the right check, sometimes a near miss or any byte
    function automatic logic [7:0] pick_check(input logic [7:0] body[$]);
        logic [7:0] good;
        good = right_check(body);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return good;
            6:                return (good == CH_UPPER_X) ? CH_LOWER_X
                                                          : 8'(CH_ZERO + $urandom_range(9));
            7, 8:             return 8'(CH_ZERO + $urandom_range(9));
            default:          return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] mid_char();
        return ($urandom_range(99) < 15) ? CH_HYPHEN : 8'(CH_ZERO + $urandom_range(9));
    endfunction

    task automatic build_m10();
        int len;
        len = $urandom_range(10, 13);
        id_buf = {CH_M};
        while (id_buf.size() < len - 1) begin
            id_buf.push_back(mid_char());
        end
    endtask

    task automatic build_g13();
        int         digits;
        int         len;
        logic [7:0] c;
        id_buf = {CH_NINE, CH_SEVEN, CH_NINE, CH_ZERO};
        digits = 4;
        while (digits < G13_DIGITS) begin
            c = mid_char();
            id_buf.push_back(c);
            if (c != CH_HYPHEN) begin
                digits++;
            end
        end
        // trailing body after the twelfth digit is ignored, so fill it with anything
        len = $urandom_range(13, 18);
        while (id_buf.size() < len - 1) begin
            id_buf.push_back($urandom_range(1) ? mid_char() : 8'($urandom_range(255)));
        end
    endtask

    // break a well-formed body: stray byte, dropped character, overlength, or pure noise
    task automatic mangle();
        case ($urandom_range(3))
            0: id_buf[$urandom_range(id_buf.size() - 1)] = 8'($urandom_range(255));
            1: begin
                if (id_buf.size() > 1) begin
                    id_buf.delete($urandom_range(1, id_buf.size() - 1));
                end
            end
            2: begin
                repeat ($urandom_range(1, 25)) id_buf.push_back(mid_char());
            end
            default: begin
                id_buf = {};
                repeat ($urandom_range(0, 39)) id_buf.push_back(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic commit(input logic [7:0] check, input logic hold);
        foreach (id_buf[i]) begin
            char_q.push_back('{ch: id_buf[i], last: 1'b0, hold: hold && (i == 0)});
        end
        char_q.push_back('{ch: check, last: 1'b1, hold: hold && (id_buf.size() == 0)});
    endtask

    task automatic note_fault(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            // move on only when the slot is empty or its character just went through
            if (!in_ch.valid || in_taken) begin
                if (char_q.size() == 0 || (!calm && $urandom_range(99) < IDLE_PCT)
                    || (char_q[0].hold && verdict_q.size() != 0)) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    cur = char_q.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.char_in <= cur.ch;
                    in_ch.is_last <= cur.last;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: samples both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;

            // input transfer: advance the predictor
            if (in_ch.valid && in_ch.ready) begin
                taken_count <= taken_count + 1;
                scan_char(scan, in_ch.char_in, in_ch.is_last, got, verdict);
                if (got) begin
                    verdict_q.push_back(verdict);
                end
            end

            // output transfer: compare with the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    note_fault($sformatf("unexpected result status=%0d form=%0d check=%02h",
                                         out_ch.status, out_ch.form_kind,
                                         out_ch.expected_check));
                end else begin
                    want = verdict_q.pop_front();
                    if (out_ch.status != want.status
                        || out_ch.form_kind != want.form_kind
                        || out_ch.expected_check != want.expected_check) begin
                        note_fault($sformatf({"result mismatch: expected status=%0d form=%0d ",
                                              "check=%02h, got status=%0d form=%0d check=%02h"},
                                             want.status, want.form_kind,
                                             want.expected_check, out_ch.status,
                                             out_ch.form_kind, out_ch.expected_check));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int n_ids;
        int roll;
        in_ch.valid   = 1'b0;
        in_ch.char_in = '0;
        in_ch.is_last = 1'b0;
        out_ch.ready  = 1'b0;
        n_ids = 0;

        // single-byte identifiers at the byte extremes, and a lone 'M'
        id_buf = {};
        commit(8'h00, 1'b0);
        commit(8'hFF, 1'b0);
        commit(CH_M, 1'b0);
        // thirteen-form prefix broken at its fourth byte
        id_buf = {CH_NINE, CH_SEVEN, CH_NINE};
        commit(8'(CH_ZERO + 1), 1'b0);
        // shortest M form whose check is 'X', then the same with lowercase 'x'
        id_buf = {CH_M, 8'(CH_ZERO + 5), CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO,
                  CH_ZERO, CH_ZERO};
        commit(CH_UPPER_X, 1'b0);
        commit(CH_LOWER_X, 1'b0);

        // random identifiers: mostly well formed with random content, some broken
        while (char_q.size() < ITEM_TARGET) begin
            roll = $urandom_range(99);
            if (roll < 36) begin
                build_m10();
            end else if (roll < 72) begin
                build_g13();
            end else begin
                if ($urandom_range(1)) begin
                    build_m10();
                end else begin
                    build_g13();
                end
                mangle();
            end
            n_ids++;
            // now and then the sender waits for every verdict to come back first
            commit(pick_check(id_buf), (n_ids % 30) == 0);
        end
        total_items = char_q.size();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_count < total_items || verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        // keep running past the last verdict to catch any stray result
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule
